// ===== hw/rtl/frcr_pkg.sv =====
// ----------------------------------------------------------------------------
// frcr_pkg
// Shared constants for the conductor Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package frcr_pkg;

    // cosine of one in signed Q2.14
    localparam logic signed [15:0] COS_ONE = 16'sd16384;

    // reflectance of one in unsigned Q1.15
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    // one in the 2^28 scale of the squared cosine
    localparam logic [28:0] SQ_ONE = 29'h1000_0000;

    // register stages from input transfer to result register
    localparam int LATENCY = 78;

endpackage

// ===== hw/rtl/frcr_if.sv =====
// ----------------------------------------------------------------------------
// frcr_in_if / frcr_out_if
// Valid/ready channels carrying one item and one result of the pipeline.
// ----------------------------------------------------------------------------
interface frcr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cos_incident;
    logic        [15:0] eta_outside_r;
    logic        [15:0] eta_outside_g;
    logic        [15:0] eta_outside_b;
    logic        [15:0] eta_inside_r;
    logic        [15:0] eta_inside_g;
    logic        [15:0] eta_inside_b;
    logic        [15:0] kappa_inside_r;
    logic        [15:0] kappa_inside_g;
    logic        [15:0] kappa_inside_b;

    modport source (
        output valid, cos_incident, eta_outside_r, eta_outside_g, eta_outside_b,
               eta_inside_r, eta_inside_g, eta_inside_b,
               kappa_inside_r, kappa_inside_g, kappa_inside_b,
        input  ready
    );
    modport sink (
        input  valid, cos_incident, eta_outside_r, eta_outside_g, eta_outside_b,
               eta_inside_r, eta_inside_g, eta_inside_b,
               kappa_inside_r, kappa_inside_g, kappa_inside_b,
        output ready
    );
endinterface

interface frcr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] reflect_r;
    logic [15:0] reflect_g;
    logic [15:0] reflect_b;
    logic        cos_was_clamped;

    modport source (
        output valid, reflect_r, reflect_g, reflect_b, cos_was_clamped,
        input  ready
    );
    modport sink (
        input  valid, reflect_r, reflect_g, reflect_b, cos_was_clamped,
        output ready
    );
endinterface

// ===== hw/rtl/frcr_chan.sv =====
// ----------------------------------------------------------------------------
// frcr_chan
// One color channel: squares, two pipelined square roots, two pipelined
// restoring dividers and the final average, all advancing on i_en.
// ----------------------------------------------------------------------------
module frcr_chan (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [14:0] i_cos,
    input  logic [15:0] i_eta_out,
    input  logic [15:0] i_eta_in,
    input  logic [15:0] i_kappa,
    output logic [15:0] o_reflect
);
    import frcr_pkg::*;

    typedef struct packed {
        logic [32:0] abs_t;
        logic        tneg;
        logic [14:0] c;
        logic [28:0] c2;
        logic [28:0] s2;
        logic [15:0] o;
        logic [59:0] c2o2;
        logic [60:0] sso;
    } t_p1;

    typedef struct packed {
        logic [33:0] root;
        logic [66:0] rem;
        t_p1         p;
    } t_sq1;

    typedef struct packed {
        logic [33:0] a;
        logic [14:0] c;
        logic [28:0] c2;
        logic [28:0] s2;
        logic [15:0] o;
        logic [59:0] c2o2;
        logic [60:0] sso;
    } t_p2;

    typedef struct packed {
        logic [16:0] root;
        logic [33:0] rem;
        t_p2         p;
    } t_sq2;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] den;
        logic [14:0] q;
        logic        sat;
    } t_div;

    typedef struct packed {
        t_div s;
        t_div p;
    } t_dv2;

    // set up a ratio: clipped numerator, denominator and the one-or-degenerate flag
    function automatic t_div f_div_init(input logic [63:0] x, input logic [63:0] z);
        t_div d;
        d.rem = (x >= z) ? (x - z) : 64'd0;
        d.den = x + z;
        d.q   = '0;
        d.sat = (d.den == 64'd0) || (d.rem >= d.den);
        return d;
    endfunction

    // one quotient bit of the restoring division
    function automatic t_div f_div_step(input t_div d);
        t_div        r;
        logic [63:0] sh;
        sh = {d.rem[62:0], 1'b0};
        r  = d;
        if (sh >= d.den) begin
            r.rem = sh - d.den;
            r.q   = {d.q[13:0], 1'b1};
        end else begin
            r.rem = sh;
            r.q   = {d.q[13:0], 1'b0};
        end
        return r;
    endfunction

    // stage 1: squares of the input codes
    logic [15:0] n_o;
    logic [28:0] n_c2;
    assign n_o  = (i_eta_out == 16'd0) ? 16'd1 : i_eta_out;
    assign n_c2 = 29'(i_cos) * 29'(i_cos);

    logic [14:0] r1_c;
    logic [28:0] r1_c2, r1_s2;
    logic [15:0] r1_o;
    logic [31:0] r1_o2, r1_n2, r1_k2;
    logic [32:0] r1_nk2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c   <= i_cos;
            r1_c2  <= n_c2;
            r1_s2  <= SQ_ONE - n_c2;
            r1_o   <= n_o;
            r1_o2  <= 32'(n_o) * 32'(n_o);
            r1_n2  <= 32'(i_eta_in) * 32'(i_eta_in);
            r1_k2  <= 32'(i_kappa) * 32'(i_kappa);
            r1_nk2 <= (33'(i_eta_in) * 33'(i_kappa)) << 1;
        end
    end

    // stage 2: sine-squared terms against the outer index
    logic [59:0] n_so, n_c2o2;
    logic [57:0] n_ss;
    assign n_so   = 60'(r1_s2) * 60'(r1_o2);
    assign n_c2o2 = 60'(r1_c2) * 60'(r1_o2);
    assign n_ss   = 58'(r1_s2) * 58'(r1_s2);

    logic [14:0] r2_c;
    logic [28:0] r2_c2, r2_s2, r2_ss;
    logic [15:0] r2_o;
    logic [31:0] r2_o2, r2_n2, r2_k2, r2_p;
    logic [32:0] r2_nk2;
    logic [59:0] r2_c2o2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_c    <= r1_c;
            r2_c2   <= r1_c2;
            r2_s2   <= r1_s2;
            r2_o    <= r1_o;
            r2_o2   <= r1_o2;
            r2_n2   <= r1_n2;
            r2_k2   <= r1_k2;
            r2_nk2  <= r1_nk2;
            r2_p    <= n_so[59:28];
            r2_c2o2 <= n_c2o2;
            r2_ss   <= n_ss[56:28];
        end
    end

    // stage 3: signed real part and its magnitude
    logic [33:0] n_t, n_tn;
    logic        n_tneg;
    assign n_t    = {2'b00, r2_n2} - {2'b00, r2_k2} - {2'b00, r2_p};
    assign n_tn   = 34'd0 - n_t;
    assign n_tneg = n_t[33];

    logic [32:0] r3_abs, r3_nk2;
    logic        r3_tneg;
    logic [14:0] r3_c;
    logic [28:0] r3_c2, r3_s2;
    logic [15:0] r3_o;
    logic [59:0] r3_c2o2;
    logic [60:0] r3_sso;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_abs  <= n_tneg ? n_tn[32:0] : n_t[32:0];
            r3_tneg <= n_tneg;
            r3_nk2  <= r2_nk2;
            r3_c    <= r2_c;
            r3_c2   <= r2_c2;
            r3_s2   <= r2_s2;
            r3_o    <= r2_o;
            r3_c2o2 <= r2_c2o2;
            r3_sso  <= 61'(r2_ss) * 61'(r2_o2);
        end
    end

    // stage 4: squares under the first root
    logic [65:0] r4_tsq, r4_msq;
    t_p1         r4_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_tsq      <= 66'(r3_abs) * 66'(r3_abs);
            r4_msq      <= 66'(r3_nk2) * 66'(r3_nk2);
            r4_p.abs_t  <= r3_abs;
            r4_p.tneg   <= r3_tneg;
            r4_p.c      <= r3_c;
            r4_p.c2     <= r3_c2;
            r4_p.s2     <= r3_s2;
            r4_p.o      <= r3_o;
            r4_p.c2o2   <= r3_c2o2;
            r4_p.sso    <= r3_sso;
        end
    end

    // stage 5 and on: first square root, one result bit per stage
    t_sq1 r_sq1 [0:34];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq1[0].root <= '0;
            r_sq1[0].rem  <= 67'(r4_tsq) + 67'(r4_msq);
            r_sq1[0].p    <= r4_p;
        end
    end

    for (genvar g = 0; g < 34; g++) begin : g_sq1
        localparam int B = 33 - g;
        logic [67:0] n_tr;
        logic        n_take;
        assign n_tr   = (68'(r_sq1[g].root) << (B + 1)) | (68'd1 << (2 * B));
        assign n_take = ({1'b0, r_sq1[g].rem} >= n_tr);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq1[g+1].p <= r_sq1[g].p;
                if (n_take) begin
                    r_sq1[g+1].root <= r_sq1[g].root | (34'd1 << B);
                    r_sq1[g+1].rem  <= 67'({1'b0, r_sq1[g].rem} - n_tr);
                end else begin
                    r_sq1[g+1].root <= r_sq1[g].root;
                    r_sq1[g+1].rem  <= r_sq1[g].rem;
                end
            end
        end
    end

    // half of magnitude plus real part feeds the second root
    logic [34:0] n_hsum;
    assign n_hsum = r_sq1[34].p.tneg
                  ? (35'(r_sq1[34].root) - 35'(r_sq1[34].p.abs_t))
                  : (35'(r_sq1[34].root) + 35'(r_sq1[34].p.abs_t));

    t_sq2 r_sq2 [0:17];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq2[0].root   <= '0;
            r_sq2[0].rem    <= n_hsum[34:1];
            r_sq2[0].p.a    <= r_sq1[34].root;
            r_sq2[0].p.c    <= r_sq1[34].p.c;
            r_sq2[0].p.c2   <= r_sq1[34].p.c2;
            r_sq2[0].p.s2   <= r_sq1[34].p.s2;
            r_sq2[0].p.o    <= r_sq1[34].p.o;
            r_sq2[0].p.c2o2 <= r_sq1[34].p.c2o2;
            r_sq2[0].p.sso  <= r_sq1[34].p.sso;
        end
    end

    for (genvar g = 0; g < 17; g++) begin : g_sq2
        localparam int B = 16 - g;
        logic [34:0] n_tr;
        logic        n_take;
        assign n_tr   = (35'(r_sq2[g].root) << (B + 1)) | (35'd1 << (2 * B));
        assign n_take = ({1'b0, r_sq2[g].rem} >= n_tr);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq2[g+1].p <= r_sq2[g].p;
                if (n_take) begin
                    r_sq2[g+1].root <= r_sq2[g].root | (17'd1 << B);
                    r_sq2[g+1].rem  <= 34'({1'b0, r_sq2[g].rem} - n_tr);
                end else begin
                    r_sq2[g+1].root <= r_sq2[g].root;
                    r_sq2[g+1].rem  <= r_sq2[g].rem;
                end
            end
        end
    end

    // product chain for the cross term and the two numerator sums
    logic [32:0] rm1_fo;
    logic [62:0] rm1_ca;
    logic [33:0] rm1_a;
    logic [14:0] rm1_c;
    logic [28:0] rm1_s2;
    logic [59:0] rm1_c2o2;
    logic [60:0] rm1_sso;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rm1_fo   <= 33'(r_sq2[17].root) * 33'(r_sq2[17].p.o);
            rm1_ca   <= 63'(r_sq2[17].p.c2) * 63'(r_sq2[17].p.a);
            rm1_a    <= r_sq2[17].p.a;
            rm1_c    <= r_sq2[17].p.c;
            rm1_s2   <= r_sq2[17].p.s2;
            rm1_c2o2 <= r_sq2[17].p.c2o2;
            rm1_sso  <= r_sq2[17].p.sso;
        end
    end

    logic [46:0] rm2_m;
    logic [63:0] rm2_x, rm2_xp;
    logic [28:0] rm2_s2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rm2_m  <= 47'(rm1_fo) * 47'(rm1_c);
            rm2_x  <= (64'(rm1_a) << 28) + 64'(rm1_c2o2);
            rm2_xp <= 64'(rm1_ca) + 64'(rm1_sso);
            rm2_s2 <= rm1_s2;
        end
    end

    logic [61:0] n_mz;
    assign n_mz = 62'(rm2_m[46:14]) * 62'(rm2_s2);

    logic [63:0] rm3_x, rm3_xp, rm3_z, rm3_zp;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rm3_x  <= rm2_x;
            rm3_xp <= rm2_xp;
            rm3_z  <= 64'(rm2_m) << 15;
            rm3_zp <= 64'(n_mz) << 1;
        end
    end

    // both ratios, one quotient bit per stage
    t_dv2 r_dv [0:15];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0].s <= f_div_init(rm3_x, rm3_z);
            r_dv[0].p <= f_div_init(rm3_xp, rm3_zp);
        end
    end

    for (genvar g = 0; g < 15; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[g+1].s <= f_div_step(r_dv[g].s);
                r_dv[g+1].p <= f_div_step(r_dv[g].p);
            end
        end
    end

    // parallel-polarized term and average
    logic [15:0] n_rs, n_rf;
    assign n_rs = r_dv[15].s.sat ? ONE_Q15 : {1'b0, r_dv[15].s.q};
    assign n_rf = r_dv[15].p.sat ? ONE_Q15 : {1'b0, r_dv[15].p.q};

    logic [15:0] rr1_rs;
    logic [31:0] rr1_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rr1_rs   <= n_rs;
            rr1_prod <= 32'(n_rs) * 32'(n_rf);
        end
    end

    logic [16:0] n_sum;
    logic [15:0] n_avg;
    assign n_sum = 17'(rr1_rs) + rr1_prod[31:15];
    assign n_avg = n_sum[16:1];

    logic [15:0] r_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= (n_avg > ONE_Q15) ? ONE_Q15 : n_avg;
        end
    end

    assign o_reflect = r_out;

endmodule

// ===== hw/rtl/fresnel_conductor_reflectance.sv =====
// ----------------------------------------------------------------------------
// fresnel_conductor_reflectance
// Unpolarized Fresnel reflectance of a dielectric-to-conductor interface for
// red, green and blue, from the incidence cosine and per-channel indices.
//
//   channel   direction   carries
//   i_item    in          cosine (Q2.14), outer/inner index, extinction (Q4.12)
//   o_result  out         reflectance per channel (Q1.15), clamp flag
//
// One item per cycle enters while the output is not stalled; each result passes
// through the two bit-per-stage square roots and the 15-stage dividers.
// Reset clears only the stage valid bits; it takes effect at the next edge,
// and i_item.ready stays low while reset is held.
// A stall at the output freezes every stage together, so i_item.ready falls
// only while a finished result waits at the output or while reset is held.
// ----------------------------------------------------------------------------
module fresnel_conductor_reflectance (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frcr_in_if.sink    i_item,
    frcr_out_if.source o_result
);
    import frcr_pkg::*;

    // pipeline advance and input acceptance
    logic n_en;
    logic n_acc;
    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] r_clp;

    assign n_en         = ~r_vld[LATENCY-1] | o_result.ready;
    assign i_item.ready = n_en & i_rst_n;
    assign n_acc        = i_item.valid & i_item.ready;

    // cosine clamp to 0..1
    logic        n_low, n_high;
    logic [14:0] n_cos;
    assign n_low  = i_item.cos_incident[15];
    assign n_high = ~n_low && (i_item.cos_incident > COS_ONE);
    assign n_cos  = n_low  ? 15'd0 :
                    n_high ? COS_ONE[14:0] : i_item.cos_incident[14:0];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[LATENCY-2:0], n_acc};
        end
    end

    // clamp flag rides alongside
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_clp <= {r_clp[LATENCY-2:0], n_low | n_high};
        end
    end

    // per-channel datapaths
    frcr_chan u_chan_r (
        .i_clk     (i_clk),
        .i_en      (n_en),
        .i_cos     (n_cos),
        .i_eta_out (i_item.eta_outside_r),
        .i_eta_in  (i_item.eta_inside_r),
        .i_kappa   (i_item.kappa_inside_r),
        .o_reflect (o_result.reflect_r)
    );

    frcr_chan u_chan_g (
        .i_clk     (i_clk),
        .i_en      (n_en),
        .i_cos     (n_cos),
        .i_eta_out (i_item.eta_outside_g),
        .i_eta_in  (i_item.eta_inside_g),
        .i_kappa   (i_item.kappa_inside_g),
        .o_reflect (o_result.reflect_g)
    );

    frcr_chan u_chan_b (
        .i_clk     (i_clk),
        .i_en      (n_en),
        .i_cos     (n_cos),
        .i_eta_out (i_item.eta_outside_b),
        .i_eta_in  (i_item.eta_inside_b),
        .i_kappa   (i_item.kappa_inside_b),
        .o_reflect (o_result.reflect_b)
    );

    assign o_result.valid           = r_vld[LATENCY-1];
    assign o_result.cos_was_clamped = r_clp[LATENCY-1];

`ifndef ASSERT_OFF
    // a transfer in always fills the first stage
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    // a stalled result stays in the output stage
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !n_en |=> r_vld[LATENCY-1])
        else $error("stalled result lost");

    // reflectance never exceeds one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.reflect_r <= ONE_Q15) &&
                           (o_result.reflect_g <= ONE_Q15) &&
                           (o_result.reflect_b <= ONE_Q15))
        else $error("reflectance above one");
`endif

endmodule
